>>> rtl/text_console_cell_writer_assert.svh
// ----------------------------------------------------------------------------
// Text console cell writer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// same-cycle implication
`define TCCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer package
// Screen geometry, field widths, datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int OP_W    = 3;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int LINE_W  = $clog2(ROWS + 1);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef logic [CHAR_W-1:0]  byte_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [LINE_W-1:0]  line_t;

  localparam byte_t  NEWLINE    = 8'h0A;
  localparam color_t LIGHT_GREY = 4'h7;

  typedef enum logic [OP_W-1:0] {
    OP_PUT     = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_SETCUR  = 3'd2,
    OP_SCROLL  = 3'd3,
    OP_RECOLOR = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    RA_CURSOR,
    RA_ADDR,
    RA_SRC
  } rd_sel_t;

  typedef enum logic [2:0] {
    WD_ZERO,
    WD_COPY,
    WD_PUT,
    WD_MARK,
    WD_PAINT
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    addr_zero;
    logic    set_cursor;
    logic    home;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    addr_inc;
    logic    remain_dec;
    logic    advance;
    logic    scroll_set;
    logic    by_count;
    logic    cell_get;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic newline;
    logic last;
    logic adv_scroll;
    logic copy_more;
    logic zero_more;
    logic rc_more;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// Text console cell writer
// 80 x 25 character/attribute screen store with cursor and command stream.
// ----------------------------------------------------------------------------
// Usage: each word on the s channel is one command (tuser = op); each command
// returns exactly one word on the m channel carrying the cursor column, row
// and linear position, plus the cell bytes for a read command.
// Steps: put char reads the cursor cell and rewrites it (no write for a
// newline), then moves the cursor; wrapping off the last row scrolls one
// line (kept cells copied up, the rest blanked) and tlast marks the
// cursor cell. Clear blanks every cell, scroll copies and blanks likewise,
// set cursor marks the new cursor cell, recolour reads and rewrites each
// painted cell. One command is in work at a time and the next is accepted
// the cycle after its result registers.
// Reset: the controller runs a clearing pass over the whole store;
// s_tready stays low until it ends. Cursor resets to the origin.
// Stall: the result sits in an output register; the next command is taken
// while it waits, and that command's result holds until m_tready frees it.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // char_code[7:0], color[11:8], col[18:12], row[23:19], fg_select[24],
  // count[35:25], zero fill
  input  logic [tccw_pkg::IN_DATA_W-1:0]      s_tdata,
  // op[2:0]
  input  logic [tccw_pkg::OP_W-1:0]           s_tuser,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // cursor_col[6:0], cursor_row[11:7], cursor_pos[22:12], cell_char[30:23],
  // cell_attr[38:31], zero fill
  output logic [tccw_pkg::OUT_DATA_W-1:0]     m_tdata
);

  tccw_pkg::dp_cmd_t  cmd;
  tccw_pkg::dp_stat_t stat;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_op    (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tccw_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .out_data (m_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console cell writer controller
// Command sequencer: decodes the op and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_cell_writer_assert.svh"

module tccw_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [tccw_pkg::OP_W-1:0]    in_op,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output tccw_pkg::dp_cmd_t            cmd,
  input  tccw_pkg::dp_stat_t           stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUT_RD,
    S_PUT_WR,
    S_ADV,
    S_SCR_SET,
    S_COPY_RD,
    S_COPY_WR,
    S_ZERO,
    S_MARK_RD,
    S_MARK_WR,
    S_RC_RD,
    S_RC_WR,
    S_CELL_RD,
    S_CELL_GET,
    S_DONE
  } state_t;

  state_t          state;
  tccw_pkg::op_t   op;
  logic            booting;
  logic            out_valid;
  logic            accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load       = 1'b1;
          cmd.addr_zero  = (tccw_pkg::op_t'(in_op) != tccw_pkg::OP_RECOLOR) &&
                           (tccw_pkg::op_t'(in_op) != tccw_pkg::OP_READ);
          cmd.set_cursor = (tccw_pkg::op_t'(in_op) == tccw_pkg::OP_SETCUR);
          cmd.home       = (tccw_pkg::op_t'(in_op) == tccw_pkg::OP_CLEAR);
        end
      end
      S_PUT_RD: begin
        cmd.rd_en  = !stat.newline;
        cmd.rd_sel = tccw_pkg::RA_CURSOR;
      end
      S_PUT_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = tccw_pkg::WD_PUT;
      end
      S_ADV: begin
        cmd.advance = 1'b1;
      end
      S_SCR_SET: begin
        cmd.scroll_set = 1'b1;
        cmd.by_count   = (op == tccw_pkg::OP_SCROLL);
      end
      S_COPY_RD: begin
        cmd.rd_en  = stat.copy_more;
        cmd.rd_sel = tccw_pkg::RA_SRC;
      end
      S_COPY_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = tccw_pkg::WD_COPY;
        cmd.addr_inc = 1'b1;
      end
      S_ZERO: begin
        cmd.wr_en    = stat.zero_more;
        cmd.wr_sel   = tccw_pkg::WD_ZERO;
        cmd.addr_inc = stat.zero_more;
      end
      S_MARK_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tccw_pkg::RA_CURSOR;
      end
      S_MARK_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = tccw_pkg::WD_MARK;
      end
      S_RC_RD: begin
        cmd.rd_en  = stat.rc_more;
        cmd.rd_sel = tccw_pkg::RA_ADDR;
      end
      S_RC_WR: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = tccw_pkg::WD_PAINT;
        cmd.addr_inc   = 1'b1;
        cmd.remain_dec = 1'b1;
      end
      S_CELL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tccw_pkg::RA_ADDR;
      end
      S_CELL_GET: begin
        cmd.cell_get = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = !out_valid || m_tready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ZERO;
      op        <= tccw_pkg::OP_PUT;
      booting   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= tccw_pkg::op_t'(in_op);
            unique case (tccw_pkg::op_t'(in_op))
              tccw_pkg::OP_PUT:     state <= S_PUT_RD;
              tccw_pkg::OP_CLEAR:   state <= S_ZERO;
              tccw_pkg::OP_SETCUR:  state <= S_MARK_RD;
              tccw_pkg::OP_SCROLL:  state <= S_SCR_SET;
              tccw_pkg::OP_RECOLOR: state <= S_RC_RD;
              tccw_pkg::OP_READ:    state <= S_CELL_RD;
              default:              state <= S_DONE;
            endcase
          end
        end
        S_PUT_RD:  state <= stat.newline ? S_ADV : S_PUT_WR;
        S_PUT_WR:  state <= S_ADV;
        S_ADV: begin
          priority if (stat.adv_scroll) begin
            state <= S_SCR_SET;
          end else if (stat.last) begin
            state <= S_MARK_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCR_SET: state <= S_COPY_RD;
        S_COPY_RD: state <= stat.copy_more ? S_COPY_WR : S_ZERO;
        S_COPY_WR: state <= S_COPY_RD;
        S_ZERO: begin
          priority if (stat.zero_more) begin
            state <= S_ZERO;
          end else if (booting) begin
            booting <= 1'b0;
            state   <= S_IDLE;
          end else if (op == tccw_pkg::OP_CLEAR) begin
            state <= S_DONE;
          end else if (op == tccw_pkg::OP_SCROLL || stat.last) begin
            state <= S_MARK_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_MARK_RD:  state <= S_MARK_WR;
        S_MARK_WR:  state <= S_DONE;
        S_RC_RD:    state <= stat.rc_more ? S_RC_WR : S_DONE;
        S_RC_WR:    state <= S_RC_RD;
        S_CELL_RD:  state <= S_CELL_GET;
        S_CELL_GET: state <= S_DONE;
        S_DONE: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TCCW_ASSERT_NOW(a_no_accept_boot, booting, !s_tready, "word accepted during clearing pass")
  `TCCW_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || m_tready, "result overwrites held word")
  `TCCW_ASSERT_NEXT(a_accept_busy, accept, state != S_IDLE, "accepted word produced no work")

endmodule

`default_nettype wire

>>> rtl/tccw_dp.sv
// ----------------------------------------------------------------------------
// Text console cell writer datapath
// Cell store, cursor, walk address and counters, output word register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_cell_writer_assert.svh"

module tccw_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  tccw_pkg::dp_cmd_t                   cmd,
  output tccw_pkg::dp_stat_t                  stat,
  input  logic [tccw_pkg::IN_DATA_W-1:0]      in_data,
  input  logic                                in_last,
  output logic [tccw_pkg::OUT_DATA_W-1:0]     out_data
);

  tccw_pkg::byte_t  in_char;
  tccw_pkg::color_t in_color;
  tccw_pkg::col_t   in_col;
  tccw_pkg::col_t   col_c;
  tccw_pkg::row_t   in_row;
  tccw_pkg::row_t   row_c;
  logic             in_fg;
  tccw_pkg::count_t in_count;

  tccw_pkg::col_t   cur_col;
  tccw_pkg::row_t   cur_row;
  tccw_pkg::cnt_t   addr;
  tccw_pkg::cnt_t   shift;
  tccw_pkg::cnt_t   start_in;
  tccw_pkg::cnt_t   cur_idx;
  tccw_pkg::cnt_t   rd_idx;
  tccw_pkg::cnt_t   wr_idx;
  logic [tccw_pkg::CNT_W:0] src;
  tccw_pkg::count_t remain;
  tccw_pkg::line_t  lines;

  tccw_pkg::byte_t  ch;
  tccw_pkg::color_t color;
  logic             fg;
  logic             last_q;
  logic             nl;
  logic             col_last;
  logic             row_last;

  tccw_pkg::cell_t  mem [tccw_pkg::CELLS];
  tccw_pkg::cell_t  rdata;
  tccw_pkg::cell_t  wdata;

  tccw_pkg::byte_t  cell_char;
  tccw_pkg::byte_t  cell_attr;
  tccw_pkg::col_t   o_col;
  tccw_pkg::row_t   o_row;
  tccw_pkg::pos_t   o_pos;
  tccw_pkg::byte_t  o_char;
  tccw_pkg::byte_t  o_attr;

  assign in_char  = in_data[7:0];
  assign in_color = in_data[11:8];
  assign in_col   = in_data[18:12];
  assign in_row   = in_data[23:19];
  assign in_fg    = in_data[24];
  assign in_count = in_data[35:25];

  assign col_c = (int'(in_col) >= tccw_pkg::COLUMNS) ?
                 tccw_pkg::col_t'(tccw_pkg::COLUMNS - 1) : in_col;
  assign row_c = (int'(in_row) >= tccw_pkg::ROWS) ?
                 tccw_pkg::row_t'(tccw_pkg::ROWS - 1) : in_row;

  assign start_in = tccw_pkg::cnt_t'(row_c) * tccw_pkg::cnt_t'(tccw_pkg::COLUMNS) +
                    tccw_pkg::cnt_t'(col_c);
  assign cur_idx  = tccw_pkg::cnt_t'(cur_row) * tccw_pkg::cnt_t'(tccw_pkg::COLUMNS) +
                    tccw_pkg::cnt_t'(cur_col);
  assign src      = {1'b0, addr} + {1'b0, shift};

  assign col_last = (int'(cur_col) == tccw_pkg::COLUMNS - 1);
  assign row_last = (int'(cur_row) == tccw_pkg::ROWS - 1);

  always_comb begin
    if (cmd.by_count) begin
      lines = (int'(remain) >= tccw_pkg::ROWS) ? tccw_pkg::line_t'(tccw_pkg::ROWS) :
                                                 tccw_pkg::line_t'(remain);
    end else begin
      lines = tccw_pkg::line_t'(1);
    end
  end

  assign stat.newline    = nl;
  assign stat.last       = last_q;
  assign stat.adv_scroll = (nl || col_last) && row_last;
  assign stat.copy_more  = (int'(src) < tccw_pkg::CELLS);
  assign stat.zero_more  = (int'(addr) < tccw_pkg::CELLS);
  assign stat.rc_more    = (remain != '0) && (int'(addr) < tccw_pkg::CELLS);

  always_comb begin
    unique case (cmd.rd_sel)
      tccw_pkg::RA_CURSOR: rd_idx = cur_idx;
      tccw_pkg::RA_ADDR:   rd_idx = addr;
      tccw_pkg::RA_SRC:    rd_idx = src[tccw_pkg::CNT_W-1:0];
      default:             rd_idx = addr;
    endcase
  end

  always_comb begin
    wr_idx = addr;
    unique case (cmd.wr_sel)
      tccw_pkg::WD_ZERO:  wdata = '0;
      tccw_pkg::WD_COPY:  wdata = rdata;
      tccw_pkg::WD_PUT: begin
        wr_idx = cur_idx;
        wdata  = {rdata[15:12], color, ch};
      end
      tccw_pkg::WD_MARK: begin
        wr_idx = cur_idx;
        wdata  = {rdata[15:12], tccw_pkg::LIGHT_GREY, rdata[7:0]};
      end
      tccw_pkg::WD_PAINT: begin
        wdata = fg ? {rdata[15:12], color, rdata[7:0]} :
                     {color, rdata[11:8], rdata[7:0]};
      end
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_idx[tccw_pkg::ADDR_W-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_idx[tccw_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      addr    <= '0;
    end else begin
      priority if (cmd.load) begin
        addr <= cmd.addr_zero ? '0 : start_in;
      end else if (cmd.scroll_set) begin
        addr <= '0;
      end else if (cmd.addr_inc) begin
        addr <= addr + 1'b1;
      end

      priority if (cmd.home) begin
        cur_col <= '0;
        cur_row <= '0;
      end else if (cmd.set_cursor) begin
        cur_col <= col_c;
        cur_row <= row_c;
      end else if (cmd.advance) begin
        if (nl || col_last) begin
          cur_col <= '0;
          if (!row_last) begin
            cur_row <= cur_row + 1'b1;
          end
        end else begin
          cur_col <= cur_col + 1'b1;
        end
      end else if (cmd.scroll_set && cmd.by_count) begin
        cur_row <= (int'(cur_row) > int'(lines)) ?
                   cur_row - tccw_pkg::row_t'(lines) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remain    <= in_count;
      ch        <= in_char;
      color     <= in_color;
      fg        <= in_fg;
      last_q    <= in_last;
      nl        <= (in_char == tccw_pkg::NEWLINE);
      cell_char <= '0;
      cell_attr <= '0;
    end else begin
      if (cmd.remain_dec) begin
        remain <= remain - 1'b1;
      end
      if (cmd.cell_get) begin
        cell_char <= rdata[7:0];
        cell_attr <= rdata[15:8];
      end
    end
    if (cmd.scroll_set) begin
      shift <= tccw_pkg::cnt_t'(lines) * tccw_pkg::cnt_t'(tccw_pkg::COLUMNS);
    end
    if (cmd.out_load) begin
      o_col  <= cur_col;
      o_row  <= cur_row;
      o_pos  <= tccw_pkg::pos_t'(cur_idx);
      o_char <= cell_char;
      o_attr <= cell_attr;
    end
  end

  assign out_data = {1'b0, o_attr, o_char, o_pos, o_row, o_col};

  `TCCW_ASSERT_NOW(a_cursor_range, 1'b1, (int'(cur_col) < tccw_pkg::COLUMNS) && (int'(cur_row) < tccw_pkg::ROWS), "cursor off screen")
  `TCCW_ASSERT_NOW(a_write_range, cmd.wr_en, int'(wr_idx) < tccw_pkg::CELLS, "cell write beyond screen")

endmodule

`default_nettype wire
